// ===== hdl/rtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and character codes for the radix text converter.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;
    localparam logic [1:0] BASE_BIN = 2'd3;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_BODY  = 2'd1,
        PH_TRAIL = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_STATUS,
        FS_DIVIDE,
        FS_EMIT
    } fmt_state_t;

    function automatic logic [4:0] radix_of(input logic [1:0] code);
        case (code)
            BASE_DEC: radix_of = 5'd10;
            BASE_OCT: radix_of = 5'd8;
            BASE_HEX: radix_of = 5'd16;
            default:  radix_of = 5'd2;
        endcase
    endfunction

    // 99 marks a non-digit
    function automatic logic [6:0] digit_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)      digit_value = 7'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h7A) digit_value = 7'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h5A) digit_value = 7'(c - 8'h41 + 8'd10);
        else                               digit_value = 7'd99;
    endfunction

    function automatic logic prefix_letter(input logic [7:0] c, input logic [1:0] code);
        case (code)
            BASE_BIN: prefix_letter = (c == 8'h62) || (c == 8'h42);
            BASE_OCT: prefix_letter = (c == 8'h6F) || (c == 8'h4F);
            BASE_HEX: prefix_letter = (c == 8'h78) || (c == 8'h58);
            default:  prefix_letter = 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        digit_char = (d < 4'd10) ? 8'(CH_ZERO + 8'(d)) : 8'(8'h41 + 8'(d) - 8'd10);
    endfunction

endpackage

// ===== hdl/radix_text_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_converter
// Parses an ASCII number text and re-formats it in four radices.
// ----------------------------------------------------------------------------
// One character is taken per cycle while the queue has room; the parser's
// multiply-add sets that rate. After the last character a queued record
// drives the formatter: it takes the record and gives the status item, then
// peels each decimal digit by long division over 16-bit chunks and each
// octal, hex or binary digit by a shift, and reads the digit store back into
// packs. A bad text gives only the status item. Result stalls hold the
// formatter. Up to four finished texts wait in the queue, so parsing continues
// while formatting runs and stops only when the queue is full.
module radix_text_converter #(
    parameter int VALUE_WIDTH = 64,
    parameter int CHARS_PER_PACK = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] character, [9:8] base_code
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] status_code, [64:1] parsed_value, [66:65] text_base,
    // [130:67] chars, [134:131] char_count, [135] text_end
    output logic [135:0] m_tdata,
    output logic         m_tuser,   // kind
    output logic         m_tlast    // final_item
);
    import rtc_pkg::*;

    logic                   pr_valid, pr_ready, pr_ok, q_valid, q_ready;
    logic [VALUE_WIDTH-1:0] pr_value;
    logic [VALUE_WIDTH:0]   q_data;
    logic                   o_status, o_end;
    logic [63:0]            o_value, o_chars;
    logic [1:0]             o_base;
    logic [3:0]             o_count;

    rtc_parser #(.VALUE_WIDTH(VALUE_WIDTH)) u_parser (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_char(s_tdata[7:0]), .in_base(s_tdata[9:8]), .in_last(s_tlast),
        .rec_valid(pr_valid), .rec_ready(pr_ready),
        .rec_ok(pr_ok), .rec_value(pr_value)
    );

    rtc_queue #(.WIDTH(VALUE_WIDTH+1), .DEPTH_LOG2(2)) u_queue (
        .aclk, .aresetn,
        .wr_valid(pr_valid && s_tready), .wr_ready(pr_ready), .wr_data({pr_ok, pr_value}),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
    );

    rtc_formatter #(.VALUE_WIDTH(VALUE_WIDTH), .CHARS_PER_PACK(CHARS_PER_PACK)) u_fmt (
        .aclk, .aresetn,
        .rec_valid(q_valid), .rec_ready(q_ready),
        .rec_ok(q_data[VALUE_WIDTH]), .rec_value(q_data[VALUE_WIDTH-1:0]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_status(o_status), .out_value(o_value),
        .out_base(o_base), .out_chars(o_chars), .out_count(o_count),
        .out_end(o_end), .out_final(m_tlast)
    );

    assign m_tdata = {o_end, o_count, o_chars, o_base, o_value, o_status};

endmodule

// ===== hdl/rtc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_parser
// Front end: takes one character per cycle while rec_ready is high, accumulates
// the value and pushes a finished-text record (ok flag, value) on the last character.
// ----------------------------------------------------------------------------
module rtc_parser #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_char,
    input  logic [1:0]             in_base,
    input  logic                   in_last,
    output logic                   rec_valid,
    input  logic                   rec_ready,
    output logic                   rec_ok,
    output logic [VALUE_WIDTH-1:0] rec_value
);
    import rtc_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [1:0]             nsp_reg, nsp_next;
    logic                   dig_reg, dig_next;
    logic                   err_reg, err_next;

    logic [VALUE_WIDTH+4:0] prod;
    logic [4:0]             radix;
    logic [6:0]             dval;
    logic                   blank, take;

    assign in_ready = rec_ready;
    assign take     = in_valid && in_ready;
    assign radix    = radix_of(in_base);
    assign dval     = digit_value(in_char);
    assign blank    = (in_char == CH_SPACE) || (in_char == CH_TAB) ||
                      (in_char == CH_LF) || (in_char == CH_CR);
    assign prod     = (VALUE_WIDTH+5)'(acc_reg) * (VALUE_WIDTH+5)'(radix)
                      + (VALUE_WIDTH+5)'(dval);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        nsp_next   = nsp_reg;
        dig_next   = dig_reg;
        err_next   = err_reg;
        if (in_char != 8'd0) begin
            if (blank) begin
                if (phase_reg == PH_BODY) phase_next = PH_TRAIL;
            end else if (phase_reg == PH_TRAIL) begin
                err_next = 1'b1;
            end else begin
                phase_next = PH_BODY;
                if (nsp_reg < 2'd2) nsp_next = nsp_reg + 2'd1;
                if (nsp_reg == 2'd1 && dig_reg && acc_reg == '0 &&
                    prefix_letter(in_char, in_base)) begin
                    dig_next = 1'b0;
                end else if (in_char != CH_UNDERSCORE) begin
                    if (dval >= 7'(radix)) begin
                        err_next = 1'b1;
                    end else begin
                        dig_next = 1'b1;
                        if (!err_reg) begin
                            if (prod[VALUE_WIDTH+4:VALUE_WIDTH] != '0) err_next = 1'b1;
                            else acc_next = prod[VALUE_WIDTH-1:0];
                        end
                    end
                end
            end
        end
    end

    assign rec_valid = in_valid && in_last;
    assign rec_ok    = !err_next && dig_next;
    assign rec_value = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            acc_reg   <= '0;
            nsp_reg   <= '0;
            dig_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end else if (take) begin
            if (in_last) begin
                phase_reg <= PH_LEAD;
                acc_reg   <= '0;
                nsp_reg   <= '0;
                dig_reg   <= 1'b0;
                err_reg   <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                nsp_reg   <= nsp_next;
                dig_reg   <= dig_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ===== hdl/rtc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_queue
// Small FIFO of finished-text records between parser and formatter.
// ----------------------------------------------------------------------------
module rtc_queue #(
    parameter int WIDTH = 65,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [DEPTH_LOG2:0] wp_reg, rp_reg;

    assign wr_ready = (wp_reg - rp_reg) != (DEPTH_LOG2+1)'(DEPTH);
    assign rd_valid = wp_reg != rp_reg;
    assign rd_data  = mem[rp_reg[DEPTH_LOG2-1:0]];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) mem[wp_reg[DEPTH_LOG2-1:0]] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 1'b1;
        end
    end

endmodule

// ===== hdl/rtc_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_formatter
// Back end: gives the status item, then for a good record peels the digits of
// each radix into the digit store (long division for decimal, shifts otherwise)
// and reads them back most significant first, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module rtc_formatter #(
    parameter int VALUE_WIDTH = 64,
    parameter int CHARS_PER_PACK = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rec_valid,
    output logic                   rec_ready,
    input  logic                   rec_ok,
    input  logic [VALUE_WIDTH-1:0] rec_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_kind,
    output logic                   out_status,
    output logic [63:0]            out_value,
    output logic [1:0]             out_base,
    output logic [63:0]            out_chars,
    output logic [3:0]             out_count,
    output logic                   out_end,
    output logic                   out_final
);
    import rtc_pkg::*;

    localparam int DW = 7;

    fmt_state_t             st_reg, st_next;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [63:0]            work_reg, work_next;
    logic [1:0]             base_reg, base_next;
    logic [DW-1:0]          n_reg, n_next;
    logic [3:0]             mem [64];
    logic [3:0]             rd_reg;
    logic                   ov_reg, ov_next;
    logic                   ok_reg, ok_next;
    logic [3:0]             digit;
    logic [63:0]            quot;
    logic                   do_wr, rd_load, take;
    logic [1:0]             ck_reg, ck_next;
    logic [3:0]             rem_reg, rem_next;
    logic [19:0]            dnum;
    logic [51:0]            dprod;
    logic [15:0]            dq;
    logic [3:0]             dr;
    logic [63:0]            dquot;

    logic                   ovalid_reg, ovalid_next;
    logic                   okind_reg, ostat_reg, oend_reg, ofin_reg;
    logic [63:0]            oval_reg, ochars_reg, ochars_next;
    logic [1:0]             obase_reg, obase_next;
    logic [3:0]             ocnt_reg, ocnt_next;
    logic                   oend_next, ofin_next, okind_next, ostat_next;
    logic [63:0]            oval_next;
    logic                   emit_now;
    logic [7:0]             ch;
    logic [VALUE_WIDTH-1:0] vsel;
    logic                   build_ok;

    // decimal: long division by 10 over four 16-bit chunks, top chunk first,
    // each chunk divided by reciprocal multiplication
    always_comb begin
        dnum  = {rem_reg, work_reg[63 - 16*int'(ck_reg) -: 16]};
        dprod = dnum * 32'hCCCC_CCCD;
        dq    = dprod[50:35];
        dr    = 4'(dnum - 20'({dq, 3'b000}) - 20'({dq, 1'b0}));
        dquot = work_reg;
        dquot[63 - 16*int'(ck_reg) -: 16] = dq;
        case (base_reg)
            BASE_DEC: begin
                quot  = dquot;
                digit = dr;
            end
            BASE_OCT: begin
                quot  = work_reg >> 3;
                digit = {1'b0, work_reg[2:0]};
            end
            BASE_HEX: begin
                quot  = work_reg >> 4;
                digit = work_reg[3:0];
            end
            default: begin
                quot  = work_reg >> 1;
                digit = {3'b0, work_reg[0]};
            end
        endcase
    end

    assign out_valid  = ovalid_reg;
    assign out_kind   = okind_reg;
    assign out_status = ostat_reg;
    assign out_value  = oval_reg;
    assign out_base   = obase_reg;
    assign out_chars  = ochars_reg;
    assign out_count  = ocnt_reg;
    assign out_end    = oend_reg;
    assign out_final  = ofin_reg;

    assign take = !ovalid_reg || out_ready;
    assign ch   = digit_char(rd_reg);
    assign vsel = val_reg;

    always_comb begin
        st_next     = st_reg;
        work_next   = work_reg;
        base_next   = base_reg;
        n_next      = n_reg;
        ov_next     = ov_reg;
        ok_next     = ok_reg;
        ck_next     = ck_reg;
        rem_next    = rem_reg;
        rec_ready   = 1'b0;
        do_wr       = 1'b0;
        rd_load     = 1'b0;
        ovalid_next = ovalid_reg && !out_ready;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        oval_next   = oval_reg;
        ochars_next = ochars_reg;
        ocnt_next   = ocnt_reg;
        oend_next   = oend_reg;
        ofin_next   = ofin_reg;
        obase_next  = obase_reg;
        emit_now    = 1'b0;
        case (st_reg)
            FS_IDLE: begin
                rec_ready = 1'b1;
                if (rec_valid) begin
                    ok_next = rec_ok;
                    st_next = FS_STATUS;
                end
            end
            FS_STATUS: begin
                if (take) begin
                    ovalid_next = 1'b1;
                    okind_next  = 1'b0;
                    ostat_next  = !ok_reg;
                    oval_next   = ok_reg ? 64'(vsel) : 64'd0;
                    ochars_next = '0;
                    ocnt_next   = '0;
                    oend_next   = 1'b0;
                    ofin_next   = !ok_reg;
                    obase_next  = BASE_DEC;
                    base_next   = BASE_DEC;
                    work_next   = 64'(vsel);
                    n_next      = '0;
                    ck_next     = '0;
                    rem_next    = '0;
                    st_next     = ok_reg ? FS_DIVIDE : FS_IDLE;
                    ochars_next = '0;
                end
            end
            FS_DIVIDE: begin
                work_next = quot;
                if (base_reg == BASE_DEC && ck_reg != 2'd3) begin
                    rem_next = digit;
                    ck_next  = ck_reg + 2'd1;
                end else begin
                    do_wr    = 1'b1;
                    rem_next = '0;
                    ck_next  = '0;
                    n_next   = n_reg + 1'b1;
                    if (quot == '0 || n_reg == DW'(63)) begin
                        st_next   = FS_EMIT;
                        rd_load   = 1'b1;
                        ov_next   = 1'b0;
                    end
                end
            end
            default: begin
                // rd_reg holds digit n_reg-1; ov_reg marks a pack pending in build
                if (take || ocnt_reg != 4'(CHARS_PER_PACK)) begin
                    if (!ov_reg) begin
                        ochars_next = '0;
                        ocnt_next   = '0;
                    end
                    ochars_next[63 - 8*int'(ov_reg ? ocnt_reg : 4'd0) -: 8] = ch;
                    ocnt_next = (ov_reg ? ocnt_reg : 4'd0) + 4'd1;
                    ov_next   = 1'b1;
                    n_next    = n_reg - 1'b1;
                    rd_load   = 1'b1;
                    if (ocnt_next == 4'(CHARS_PER_PACK) || n_reg == DW'(1)) begin
                        emit_now    = 1'b1;
                        ovalid_next = 1'b1;
                        okind_next  = 1'b1;
                        ostat_next  = 1'b0;
                        oval_next   = '0;
                        obase_next  = base_reg;
                        oend_next   = (n_reg == DW'(1));
                        ofin_next   = (n_reg == DW'(1)) && (base_reg == BASE_BIN);
                        ov_next     = 1'b0;
                        if (n_reg == DW'(1)) begin
                            base_next = base_reg + 2'd1;
                            work_next = 64'(vsel);
                            n_next    = '0;
                            st_next   = (base_reg == BASE_BIN) ? FS_IDLE : FS_DIVIDE;
                        end
                    end
                end
            end
        endcase
    end

    // the pack under construction lives in the output register; stall when it
    // is shown and not yet taken
    assign build_ok = (st_reg != FS_EMIT) || !ovalid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) mem[n_reg[5:0]] <= digit;
    end

    // the top digit is written in the same cycle it is first read
    always_ff @(posedge aclk) begin
        if (rd_load && build_ok) rd_reg <= do_wr ? digit : mem[6'(n_next - 1'b1)];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= FS_IDLE;
            ovalid_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else if (build_ok) begin
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
            ov_reg     <= ov_next;
        end else begin
            ovalid_reg <= ovalid_reg && !out_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == FS_IDLE && rec_valid) val_reg <= rec_value;
        if (build_ok) begin
            work_reg   <= work_next;
            base_reg   <= base_next;
            n_reg      <= n_next;
            ok_reg     <= ok_next;
            ck_reg     <= ck_next;
            rem_reg    <= rem_next;
            okind_reg  <= okind_next;
            ostat_reg  <= ostat_next;
            oval_reg   <= oval_next;
            ochars_reg <= ochars_next;
            ocnt_reg   <= ocnt_next;
            oend_reg   <= oend_next;
            ofin_reg   <= ofin_next;
            obase_reg  <= obase_next;
        end
    end

endmodule

// ===== hdl/radix_text_converter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_converter_sva
// Port-level checks of the converter's result stream.
// ----------------------------------------------------------------------------
module radix_text_converter_sva (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_bad_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[0] |-> m_tlast)
        else $error("invalid status not final");

    a_pack_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[134:131] != 4'd0)
        else $error("empty pack");

    a_final_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tlast |-> m_tdata[135])
        else $error("final pack without text end");
endmodule

bind radix_text_converter radix_text_converter_sva u_sva (.*);
